// ===== rtl/core/mp3_header_and_vbr_tag_parser_unit_defines.svh =====
// Assertion macros for the mp3 header and VBR tag parser unit.
// Used by mhvp_queue.sv under rtl/core; expects clk and rst_n in scope.
`ifndef MP3_HEADER_AND_VBR_TAG_PARSER_UNIT_DEFINES_SVH
`define MP3_HEADER_AND_VBR_TAG_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MHVP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mhvp assertion failed");
`define MHVP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mhvp assertion failed");
`else
`define MHVP_ASSERT_IMP(lbl, pre, post)
`define MHVP_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/mhvp_pkg.sv =====
// Package for the mp3 header and VBR tag parser: types, constants, lookup tables.
// No dependencies.
`default_nettype none
package mhvp_pkg;

    localparam int PosMax   = 63;
    localparam int VbriAt   = 36;
    localparam int XingLen  = 12;
    localparam int VbriEnd  = 54;
    localparam int QDepth   = 2;
    localparam int DivBits  = 53;
    localparam int ProdW    = 53;

    localparam logic [7:0]  SyncByte = 8'hFF;
    localparam logic [7:0]  SyncMask = 8'hE0;
    localparam logic [31:0] FlagFrames = 32'h0000_0001;
    localparam logic [10:0] SamplesV1 = 11'd1152;
    localparam logic [10:0] SamplesV2 = 11'd576;
    localparam logic [20:0] MsScaleV1 = 21'(1152 * 1000);
    localparam logic [20:0] MsScaleV2 = 21'(576 * 1000);

    localparam logic [1:0] VerV1       = 2'b11;
    localparam logic [1:0] VerV2       = 2'b10;
    localparam logic [1:0] VerReserved = 2'b01;
    localparam logic [1:0] LayerIII    = 2'b01;
    localparam logic [1:0] ModeMono    = 2'b11;
    localparam logic [3:0] BriBad      = 4'hF;
    localparam logic [1:0] SriBad      = 2'b11;

    localparam logic [1:0] TagNone = 2'd0;
    localparam logic [1:0] TagXing = 2'd1;
    localparam logic [1:0] TagVbri = 2'd2;

    typedef struct packed {
        logic        ok;
        logic [15:0] rate;
        logic [18:0] bitrate;
        logic [1:0]  chans;
        logic [10:0] samples;
        logic [5:0]  side;
    } hdr_t;

    typedef struct packed {
        logic        header_ok;
        logic [15:0] sample_rate_hz;
        logic [18:0] bit_rate;
        logic [1:0]  channel_count;
        logic [10:0] frame_samples;
        logic [5:0]  side_info_len;
        logic [1:0]  tag_found;
        logic [31:0] frame_total;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } back_state_t;

    function automatic logic [18:0] bps_v1(input logic [3:0] idx);
        case (idx)
            4'd1:    return 19'd32000;
            4'd2:    return 19'd40000;
            4'd3:    return 19'd48000;
            4'd4:    return 19'd56000;
            4'd5:    return 19'd64000;
            4'd6:    return 19'd80000;
            4'd7:    return 19'd96000;
            4'd8:    return 19'd112000;
            4'd9:    return 19'd128000;
            4'd10:   return 19'd160000;
            4'd11:   return 19'd192000;
            4'd12:   return 19'd224000;
            4'd13:   return 19'd256000;
            4'd14:   return 19'd320000;
            default: return 19'd0;
        endcase
    endfunction

    function automatic logic [18:0] bps_v2(input logic [3:0] idx);
        case (idx)
            4'd1:    return 19'd8000;
            4'd2:    return 19'd16000;
            4'd3:    return 19'd24000;
            4'd4:    return 19'd32000;
            4'd5:    return 19'd40000;
            4'd6:    return 19'd48000;
            4'd7:    return 19'd56000;
            4'd8:    return 19'd64000;
            4'd9:    return 19'd80000;
            4'd10:   return 19'd96000;
            4'd11:   return 19'd112000;
            4'd12:   return 19'd128000;
            4'd13:   return 19'd144000;
            4'd14:   return 19'd160000;
            default: return 19'd0;
        endcase
    endfunction

    function automatic logic [15:0] rate_hz(input logic [1:0] ver, input logic [1:0] sri);
        logic [3:0] key;
        key = {ver, sri};
        case (key)
            {VerV1, 2'd0}: return 16'd44100;
            {VerV1, 2'd1}: return 16'd48000;
            {VerV1, 2'd2}: return 16'd32000;
            {VerV2, 2'd0}: return 16'd22050;
            {VerV2, 2'd1}: return 16'd24000;
            {VerV2, 2'd2}: return 16'd16000;
            4'b0000, 4'b0100: return 16'd11025;
            4'b0001, 4'b0101: return 16'd12000;
            4'b0010, 4'b0110: return 16'd8000;
            default: return 16'd0;
        endcase
    endfunction

    function automatic hdr_t decode_hdr(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
        hdr_t h;
        logic v1;
        logic mono;
        v1 = (b1[4:3] == VerV1);
        mono = (b3[7:6] == ModeMono);
        h.rate = rate_hz(b1[4:3], b2[3:2]);
        h.bitrate = v1 ? bps_v1(b2[7:4]) : bps_v2(b2[7:4]);
        h.chans = mono ? 2'd1 : 2'd2;
        h.samples = v1 ? SamplesV1 : SamplesV2;
        h.side = v1 ? (mono ? 6'd17 : 6'd32) : (mono ? 6'd9 : 6'd17);
        h.ok = (b0 == SyncByte) && ((b1 & SyncMask) == SyncMask) &&
               (b1[4:3] != VerReserved) && (b1[2:1] == LayerIII) &&
               (b2[7:4] != BriBad) && (b2[3:2] != SriBad) && (h.rate != 16'd0);
        return h;
    endfunction

    function automatic logic [7:0] xing_char(input logic [1:0] k);
        case (k)
            2'd0:    return 8'h58;
            2'd1:    return 8'h69;
            2'd2:    return 8'h6E;
            default: return 8'h67;
        endcase
    endfunction

    function automatic logic [7:0] info_char(input logic [1:0] k);
        case (k)
            2'd0:    return 8'h49;
            2'd1:    return 8'h6E;
            2'd2:    return 8'h66;
            default: return 8'h6F;
        endcase
    endfunction

    function automatic logic [7:0] vbri_char(input logic [1:0] k);
        case (k)
            2'd0:    return 8'h56;
            2'd1:    return 8'h42;
            2'd2:    return 8'h52;
            default: return 8'h49;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mhvp_front.sv =====
// Front end: takes buffer bytes, decodes the header, scans for Xing/Info/VBRI tags.
// Emits one job per buffer into the queue. Depends on mhvp_pkg.
`default_nettype none
module mhvp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_last,
    input  wire mhvp_pkg::q_status_t q_status,
    output logic                    push,
    output mhvp_pkg::job_t          push_job
);
    import mhvp_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  hdr_reg [0:3];
    logic [7:0]  hdr_next [0:3];
    logic        xmatch_reg, xmatch_next;
    logic        imatch_reg, imatch_next;
    logic        vmatch_reg, vmatch_next;
    logic [31:0] flag_reg, flag_next;
    logic [31:0] xcount_reg, xcount_next;
    logic [31:0] vcount_reg, vcount_next;

    hdr_t       hdr_cur;
    hdr_t       hdr_fin;
    logic [5:0] xoff;
    logic [5:0] koff;
    logic [6:0] len;
    logic [6:0] xend_fin;
    logic       accept;
    logic [1:0] tag;
    logic [31:0] frames;

    assign in_ready = !q_status.full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        xmatch_next = xmatch_reg;
        imatch_next = imatch_reg;
        vmatch_next = vmatch_reg;
        flag_next   = flag_reg;
        xcount_next = xcount_reg;
        vcount_next = vcount_reg;
        hdr_cur = decode_hdr(hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]);
        xoff = 6'd4 + hdr_cur.side;
        koff = pos_reg - xoff;
        if (accept)
        begin
            if (pos_reg < 6'd4)
            begin
                hdr_next[pos_reg[1:0]] = in_byte;
            end
            else if (pos_reg < 6'(PosMax))
            begin
                if (pos_reg >= xoff && pos_reg < xoff + 6'(XingLen))
                begin
                    if (koff < 6'd4)
                    begin
                        if (in_byte != xing_char(koff[1:0]))
                        begin
                            xmatch_next = 1'b0;
                        end
                        if (in_byte != info_char(koff[1:0]))
                        begin
                            imatch_next = 1'b0;
                        end
                    end
                    else if (koff < 6'd8)
                    begin
                        flag_next = {flag_reg[23:0], in_byte};
                    end
                    else
                    begin
                        xcount_next = {xcount_reg[23:0], in_byte};
                    end
                end
                if (pos_reg >= 6'(VbriAt) && pos_reg < 6'(VbriAt + 4))
                begin
                    if (in_byte != vbri_char(2'(pos_reg - 6'(VbriAt))))
                    begin
                        vmatch_next = 1'b0;
                    end
                end
                else if (pos_reg >= 6'(VbriAt + 14) && pos_reg < 6'(VbriAt + 18))
                begin
                    vcount_next = {vcount_reg[23:0], in_byte};
                end
            end
            if (pos_reg < 6'(PosMax))
            begin
                pos_next = pos_reg + 6'd1;
            end
        end

        hdr_fin = decode_hdr(hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]);
        len = {1'b0, pos_reg} + 7'd1;
        xend_fin = 7'd4 + {1'b0, hdr_fin.side} + 7'(XingLen);
        tag = TagNone;
        frames = 32'd0;
        if (xend_fin <= len && (xmatch_next || imatch_next))
        begin
            tag = TagXing;
            if ((flag_next & FlagFrames) != 32'd0)
            begin
                frames = xcount_next;
            end
        end
        else if (7'(VbriEnd) <= len && vmatch_next)
        begin
            tag = TagVbri;
            frames = vcount_next;
        end

        push = accept && in_last;
        push_job = '0;
        if (len >= 7'd4 && hdr_fin.ok)
        begin
            push_job.header_ok      = 1'b1;
            push_job.sample_rate_hz = hdr_fin.rate;
            push_job.bit_rate       = hdr_fin.bitrate;
            push_job.channel_count  = hdr_fin.chans;
            push_job.frame_samples  = hdr_fin.samples;
            push_job.side_info_len  = hdr_fin.side;
            push_job.tag_found      = tag;
            push_job.frame_total    = frames;
        end

        if (push)
        begin
            pos_next    = 6'd0;
            hdr_next    = '{default: 8'd0};
            xmatch_next = 1'b1;
            imatch_next = 1'b1;
            vmatch_next = 1'b1;
            flag_next   = 32'd0;
            xcount_next = 32'd0;
            vcount_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 6'd0;
            hdr_reg    <= '{default: 8'd0};
            xmatch_reg <= 1'b1;
            imatch_reg <= 1'b1;
            vmatch_reg <= 1'b1;
            flag_reg   <= 32'd0;
            xcount_reg <= 32'd0;
            vcount_reg <= 32'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hdr_reg    <= hdr_next;
            xmatch_reg <= xmatch_next;
            imatch_reg <= imatch_next;
            vmatch_reg <= vmatch_next;
            flag_reg   <= flag_next;
            xcount_reg <= xcount_next;
            vcount_reg <= vcount_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mhvp_queue.sv =====
// Two-entry job queue between the byte front end and the duration back end.
// Depends on mhvp_pkg and the assertion macro header.
`default_nettype none
`include "mp3_header_and_vbr_tag_parser_unit_defines.svh"
module mhvp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire mhvp_pkg::job_t      push_job,
    input  wire logic                pop,
    output mhvp_pkg::job_t           pop_job,
    output mhvp_pkg::q_status_t      q_status
);
    import mhvp_pkg::*;

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    job_t            ent_reg [0:QDepth-1];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CntW'(QDepth));
    assign q_status.empty = (count_reg == '0);
    assign pop_job = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end

    `MHVP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CntW'(QDepth))
    `MHVP_ASSERT_IMP(a_no_push_full, q_status.full, !push)
    `MHVP_ASSERT_IMP(a_no_pop_empty, q_status.empty, !pop)
    `MHVP_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + CntW'(1))

endmodule
`default_nettype wire

// ===== rtl/core/mhvp_back.sv =====
// Back end: frames * samples * 1000 / rate with one multiply and a bit-serial divider.
// Holds the finished result in an output register. Depends on mhvp_pkg.
`default_nettype none
module mhvp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mhvp_pkg::q_status_t q_status,
    input  wire mhvp_pkg::job_t      pop_job,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mhvp_pkg::job_t           out_job,
    output logic [31:0]              out_duration
);
    import mhvp_pkg::*;

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [ProdW-1:0] prod_reg, prod_next;
    logic [15:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [5:0]       cnt_reg, cnt_next;

    logic [20:0] ms_scale;
    logic [16:0] trial;
    logic        qbit;

    assign ms_scale = (job_reg.frame_samples == SamplesV1) ? MsScaleV1 : MsScaleV2;
    assign trial = {rem_reg, prod_reg[ProdW-1]};
    assign qbit = (trial >= {1'b0, job_reg.sample_rate_hz});

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    job_next = pop_job;
                    quo_next = 32'd0;
                    if (pop_job.frame_total == 32'd0)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = ProdW'(job_reg.frame_total) * ProdW'(ms_scale);
                rem_next   = 16'd0;
                cnt_next   = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = qbit ? 16'(trial - {1'b0, job_reg.sample_rate_hz}) : trial[15:0];
                quo_next  = {quo_reg[30:0], qbit};
                prod_next = {prod_reg[ProdW-2:0], 1'b0};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DivBits - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign out_job      = job_reg;
    assign out_duration = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mp3_header_and_vbr_tag_parser_unit.sv =====
// Top level of the mp3 header and VBR tag parser: front end, job queue, back end.
// Depends on mhvp_pkg, mhvp_front, mhvp_queue and mhvp_back.
//
// Bytes of one frame buffer stream in on the slave side, one transfer per cycle,
// with tlast on the final byte; each buffer yields exactly one result transfer on
// the master side. The front end takes one byte every cycle while the two-entry job
// queue has room. Each result pops its job, passes through the 32x21 multiplier
// and the bit-serial divider, then waits on the master side until m_tready is
// high; a result whose frame count is zero skips the multiplier and divider.
// Buffers of at least 56 bytes run at one byte per cycle with m_tready held high.
`default_nettype none
module mp3_header_and_vbr_tag_parser_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          s_tlast,   // last_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // sample_rate_hz[15:0], bit_rate[34:16], channel_count[36:35],
    // frame_samples[47:37], side_info_len[53:48], tag_found[55:54],
    // frame_total[87:56], duration_ms[119:88]
    output logic [119:0]       m_tdata,
    output logic               m_tuser    // header_ok
);
    import mhvp_pkg::*;

    q_status_t   q_status;
    logic        push;
    job_t        push_job;
    logic        pop;
    job_t        pop_job;
    job_t        out_job;
    logic [31:0] out_duration;

    mhvp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    mhvp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    mhvp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_job      (out_job),
        .out_duration (out_duration)
    );

    assign m_tuser = out_job.header_ok;
    assign m_tdata = {out_duration, out_job.frame_total, out_job.tag_found,
                      out_job.side_info_len, out_job.frame_samples,
                      out_job.channel_count, out_job.bit_rate,
                      out_job.sample_rate_hz};

endmodule
`default_nettype wire

// ===== tb/sv/tb_mp3_header_and_vbr_tag_parser_unit.sv =====
`timescale 1ns / 1ps
// Testbench for mp3_header_and_vbr_tag_parser_unit: frame buffers go in on the byte stream,
// a scoreboard class predicts each per-buffer summary and checks the result stream.
// Depends on mhvp_pkg for header field codes and tag codes.
import mhvp_pkg::*;

typedef bit [7:0] byte_q_t[$];

typedef struct packed {
    bit        ok;
    bit [15:0] rate;
    bit [18:0] bitrate;
    bit [1:0]  chans;
    bit [10:0] samples;
    bit [5:0]  side;
    bit [1:0]  tag;
    bit [31:0] frames;
    bit [31:0] dur;
} frame_summary_t;

typedef enum {PLANT_NONE, PLANT_XING, PLANT_INFO, PLANT_VBRI} tag_plant_e;
typedef enum {FAULT_SYNC0, FAULT_SYNC1, FAULT_VERSION, FAULT_LAYER, FAULT_BITRATE,
              FAULT_RATE} header_fault_e;

localparam bit [31:0] XingId = "Xing";
localparam bit [31:0] InfoId = "Info";
localparam bit [31:0] VbriId = "VBRI";
localparam bit [1:0]  VerV25 = 2'b00;

class mp3_summary_board;
    int unsigned kbps_mpeg1[16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                    256, 320, 0};
    int unsigned kbps_mpeg2[16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                    144, 160, 0};
    // indexed by version bits, then sample-rate index
    int unsigned rate_by_ver[4][3] = '{'{11025, 12000, 8000}, '{11025, 12000, 8000},
                                       '{22050, 24000, 16000}, '{44100, 48000, 32000}};

    int             pos;
    bit [7:0]       hdr[4];
    bit             xing_hit;
    bit             info_hit;
    bit             vbri_hit;
    bit [31:0]      xing_flags;
    bit [31:0]      xing_frames;
    bit [31:0]      vbri_frames;
    frame_summary_t pending_summaries[$];
    int             errors;
    int             results_seen;

    function new();
        clear();
        errors = 0;
        results_seen = 0;
    endfunction

    function void clear();
        pos = 0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        xing_hit = 1'b1;
        info_hit = 1'b1;
        vbri_hit = 1'b1;
        xing_flags = '0;
        xing_frames = '0;
        vbri_frames = '0;
    endfunction

    // header fields from the stored bytes, filled in even when the header is bad
    function void decode(output frame_summary_t s);
        bit [1:0] ver;
        bit [1:0] layer;
        bit [3:0] bri;
        bit [1:0] sri;
        bit       v1;
        bit       mono;
        ver = hdr[1][4:3];
        layer = hdr[1][2:1];
        bri = hdr[2][7:4];
        sri = hdr[2][3:2];
        v1 = (ver == VerV1);
        mono = (hdr[3][7:6] == ModeMono);
        s = '0;
        s.rate = (sri == SriBad) ? 16'd0 : 16'(rate_by_ver[ver][sri]);
        s.bitrate = 19'((v1 ? kbps_mpeg1[bri] : kbps_mpeg2[bri]) * 1000);
        s.chans = mono ? 2'd1 : 2'd2;
        s.samples = v1 ? 11'd1152 : 11'd576;
        s.side = v1 ? (mono ? 6'd17 : 6'd32) : (mono ? 6'd9 : 6'd17);
        s.ok = (hdr[0] == SyncByte) && ((hdr[1] & SyncMask) == SyncMask) &&
               (ver != VerReserved) && (layer == LayerIII) && (bri != BriBad) &&
               (sri != SriBad) && (s.rate != 16'd0);
    endfunction

    function void take_byte(bit [7:0] b, bit last);
        frame_summary_t  s;
        int              xoff;
        int              len;
        int              k;
        bit [31:0]       frames;
        longint unsigned scaled;
        if (pos < 4) begin
            hdr[pos] = b;
        end
        else if (pos < PosMax) begin
            decode(s);
            xoff = 4 + s.side;
            if (pos >= xoff && pos < xoff + XingLen) begin
                k = pos - xoff;
                if (k < 4) begin
                    if (b != XingId[31 - 8 * k -: 8]) xing_hit = 1'b0;
                    if (b != InfoId[31 - 8 * k -: 8]) info_hit = 1'b0;
                end
                else if (k < 8) begin
                    xing_flags = {xing_flags[23:0], b};
                end
                else begin
                    xing_frames = {xing_frames[23:0], b};
                end
            end
            if (pos >= VbriAt && pos < VbriAt + 4) begin
                if (b != VbriId[31 - 8 * (pos - VbriAt) -: 8]) vbri_hit = 1'b0;
            end
            else if (pos >= VbriAt + 14 && pos < VbriAt + 18) begin
                vbri_frames = {vbri_frames[23:0], b};
            end
        end
        len = pos + 1;
        if (pos < PosMax) pos++;
        if (!last) return;

        decode(s);
        if (len >= 4 && s.ok) begin
            frames = '0;
            s.tag = TagNone;
            if (4 + s.side + XingLen <= len && (xing_hit || info_hit)) begin
                s.tag = TagXing;
                if ((xing_flags & FlagFrames) != 0) frames = xing_frames;
            end
            else if (VbriEnd <= len && vbri_hit) begin
                s.tag = TagVbri;
                frames = vbri_frames;
            end
            s.frames = frames;
            if (frames != 0) begin
                scaled = 64'(frames) * 64'(s.samples) * 64'd1000 / 64'(s.rate);
                s.dur = scaled[31:0];
            end
        end
        else begin
            s = '0;
        end
        pending_summaries.push_back(s);
        clear();
    endfunction

    function int outstanding();
        return pending_summaries.size();
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH %s", msg);
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    task check_summary(logic [119:0] d, logic ok);
        frame_summary_t want;
        results_seen++;
        if (pending_summaries.size() == 0) begin
            report($sformatf("result %0d arrived with no buffer outstanding", results_seen));
            return;
        end
        want = pending_summaries.pop_front();
        field_check("header_ok", ok, want.ok);
        field_check("sample_rate_hz", d[15:0], want.rate);
        field_check("bit_rate", d[34:16], want.bitrate);
        field_check("channel_count", d[36:35], want.chans);
        field_check("frame_samples", d[47:37], want.samples);
        field_check("side_info_len", d[53:48], want.side);
        field_check("tag_found", d[55:54], want.tag);
        field_check("frame_total", d[87:56], want.frames);
        field_check("duration_ms", d[119:88], want.dur);
    endtask
endclass

module tb_mp3_header_and_vbr_tag_parser_unit;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;   // data_byte
    logic          s_tlast;   // last_byte
    logic          m_tvalid;
    logic          m_tready;
    // sample_rate_hz, bit_rate, channel_count, frame_samples, side_info_len,
    // tag_found, frame_total, duration_ms
    logic [119:0]  m_tdata;
    logic          m_tuser;   // header_ok

    mp3_summary_board board = new();

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit stall_request = 1'b0;

    mp3_header_and_vbr_tag_parser_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic void put_byte(ref byte_q_t q, input int idx, input bit [7:0] v);
        if (idx < q.size()) q[idx] = v;
    endfunction

    function automatic void put_word(ref byte_q_t q, input int idx, input bit [31:0] w);
        for (int k = 0; k < 4; k++) put_byte(q, idx + k, w[31 - 8 * k -: 8]);
    endfunction

    function automatic byte_q_t make_frame(input bit [1:0] ver, input bit [3:0] bri,
                                           input bit [1:0] sri, input bit [1:0] mode,
                                           input tag_plant_e plant, input bit [31:0] flags,
                                           input bit [31:0] count, input int len);
        byte_q_t q;
        int      xoff;
        xoff = 4 + ((ver == VerV1) ? ((mode == ModeMono) ? 17 : 32)
                                   : ((mode == ModeMono) ? 9 : 17));
        for (int i = 0; i < len; i++) q.push_back(8'($urandom));
        put_byte(q, 0, SyncByte);
        put_byte(q, 1, {3'b111, ver, LayerIII, 1'($urandom)});
        put_byte(q, 2, {bri, sri, 2'($urandom)});
        put_byte(q, 3, {mode, 6'($urandom)});
        case (plant)
            PLANT_XING, PLANT_INFO:
            begin
                put_word(q, xoff, (plant == PLANT_XING) ? XingId : InfoId);
                put_word(q, xoff + 4, flags);
                put_word(q, xoff + 8, count);
            end
            PLANT_VBRI:
            begin
                put_word(q, VbriAt, VbriId);
                put_word(q, VbriAt + 14, count);
            end
            default:
            begin
            end
        endcase
        return q;
    endfunction

    function automatic void break_header(ref byte_q_t q, input header_fault_e f);
        if (q.size() < 4) return;
        case (f)
            FAULT_SYNC0:   q[0] = 8'h7F;
            FAULT_SYNC1:   q[1] = q[1] ^ 8'h20;
            FAULT_VERSION: q[1][4:3] = VerReserved;
            FAULT_LAYER:   q[1][2:1] = 2'b11;
            FAULT_BITRATE: q[2][7:4] = BriBad;
            default:       q[2][3:2] = SriBad;
        endcase
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit last);
        @(negedge clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        board.take_byte(b, last);
    endtask

    task automatic send_buffer(input byte_q_t q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold;
        bit stall_done;
        hold = 0;
        stall_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_request && !stall_done) begin
                hold = 600;
                stall_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            board.check_summary(m_tdata, m_tuser);
    end

    initial
    begin
        #8_000_000;
        $display("mp3_header_and_vbr_tag_parser_unit verification failed");
        $finish;
    end

    initial
    begin
        byte_q_t     frame_q;
        bit [1:0]    ver;
        bit [3:0]    bri;
        bit [1:0]    sri;
        bit [1:0]    mode;
        tag_plant_e  plant;
        bit [31:0]   flags;
        bit [31:0]   count;
        int          len;
        int          sel;
        int          idx;
        int          phase_bytes;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        src_idle_pct = 31;
        snk_idle_pct = 45;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed buffers
        send_buffer(make_frame(VerV1, 4'd14, 2'd0, 2'd0, PLANT_XING, 32'h0000_000F,
                               32'd5000, 48));
        send_buffer(make_frame(VerV1, 4'd1, 2'd1, ModeMono, PLANT_INFO, 32'hFFFF_FFFE,
                               32'd777, 40));
        send_buffer(make_frame(VerV2, 4'd14, 2'd1, 2'd1, PLANT_VBRI, 32'h0, 32'd123456, 54));
        send_buffer(make_frame(VerV25, 4'd0, 2'd2, ModeMono, PLANT_XING, 32'h1,
                               32'hFFFF_FFFF, 25));
        // tag windows one byte short
        send_buffer(make_frame(VerV2, 4'd5, 2'd2, ModeMono, PLANT_XING, 32'h1, 32'd1000, 24));
        send_buffer(make_frame(VerV25, 4'd9, 2'd0, 2'd2, PLANT_VBRI, 32'h0, 32'd99, 53));
        // Xing with flag clear still wins over a good VBRI
        frame_q = make_frame(VerV2, 4'd3, 2'd0, 2'd0, PLANT_XING, 32'h0, 32'd50, 60);
        put_word(frame_q, VbriAt, VbriId);
        put_word(frame_q, VbriAt + 14, 32'd42);
        send_buffer(frame_q);
        for (int f = 0; f < 6; f++) begin
            frame_q = make_frame(VerV1, 4'd9, 2'd0, 2'd0, PLANT_XING, 32'h1, 32'd10, 48);
            break_header(frame_q, header_fault_e'(f));
            send_buffer(frame_q);
        end
        // short buffers
        send_buffer({8'hFF});
        send_buffer({8'hFF, 8'hFB, 8'h90});
        send_buffer(make_frame(VerV1, 4'd9, 2'd0, 2'd0, PLANT_NONE, 32'h0, 32'h0, 4));
        // long buffer, position saturates
        send_buffer(make_frame(VerV1, 4'd7, 2'd2, 2'd1, PLANT_VBRI, 32'h0, 32'd3000, 100));
        frame_q = {};
        repeat (64) frame_q.push_back(8'h00);
        send_buffer(frame_q);
        frame_q = {};
        repeat (10) frame_q.push_back(8'hFF);
        send_buffer(frame_q);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    src_idle_pct = 31;
                    snk_idle_pct = 45;
                end
                1:
                begin
                    src_idle_pct = 45;
                    snk_idle_pct = 31;
                    stall_request = 1'b1;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 360) begin
                case ($urandom_range(19))
                    0:       ver = VerReserved;
                    1, 2, 3,
                    4, 5, 6: ver = VerV1;
                    7, 8, 9,
                    10, 11,
                    12:      ver = VerV2;
                    default: ver = VerV25;
                endcase
                bri = ($urandom_range(19) == 0) ? BriBad : 4'($urandom_range(14));
                sri = ($urandom_range(19) == 0) ? SriBad : 2'($urandom_range(2));
                mode = 2'($urandom);
                plant = tag_plant_e'($urandom_range(3));
                flags = $urandom;
                if ($urandom_range(4) != 0) flags[0] = 1'b1;
                case ($urandom_range(9))
                    0:       count = 32'h0;
                    1:       count = 32'hFFFF_FFFF;
                    2, 3, 4: count = $urandom_range(20000, 1);
                    default: count = $urandom;
                endcase
                // exact and one-short windows for each side-info size and for VBRI
                case ($urandom_range(11))
                    0:       len = 25;
                    1:       len = 24;
                    2:       len = 33;
                    3:       len = 32;
                    4:       len = 48;
                    5:       len = 47;
                    6:       len = 54;
                    7:       len = 53;
                    8:       len = $urandom_range(90, 63);
                    9:       len = $urandom_range(8, 1);
                    default: len = $urandom_range(64, 4);
                endcase
                frame_q = make_frame(ver, bri, sri, mode, plant, flags, count, len);
                sel = $urandom_range(99);
                if (sel < 8) begin
                    frame_q = {};
                    repeat ($urandom_range(70, 1)) frame_q.push_back(8'($urandom));
                end
                else if (sel < 16) begin
                    break_header(frame_q, header_fault_e'($urandom_range(5)));
                end
                else if (sel < 28 && frame_q.size() > 4) begin
                    idx = $urandom_range(frame_q.size() - 1);
                    frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(7));
                end
                send_buffer(frame_q);
                phase_bytes += frame_q.size();
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0) begin
            $display("mp3_header_and_vbr_tag_parser_unit verification clean");
        end
        else begin
            $display("mp3_header_and_vbr_tag_parser_unit verification failed");
        end
        $finish;
    end

endmodule
